### rtl/core/mogaf_pkg.sv
// Shared constants and types for the median-of-groups average filter.
`default_nettype none

package mogaf_pkg;

   // Samples per group, groups per output, and sample resolution.
   localparam int GROUP_SIZE  = 5;
   localparam int NUM_GROUPS  = 4;
   localparam int SAMPLE_BITS = 12;

   // Stream data bus width: fields rounded up to whole bytes.
   localparam int TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;

   // Rank of the median in ascending order (upper middle for even sizes).
   localparam int MEDIAN_RANK = GROUP_SIZE / 2;

   localparam int POS_BITS    = $clog2(GROUP_SIZE);
   localparam int IDX_BITS    = (GROUP_SIZE > 2) ? $clog2(GROUP_SIZE - 1) : 1;
   localparam int GRP_BITS    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int RANK_BITS   = $clog2(GROUP_SIZE);
   localparam int SUM_BITS    = SAMPLE_BITS + GRP_BITS;

   typedef logic [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SUM_BITS-1:0]    sum_type;
   typedef logic [GROUP_SIZE-1:0][SAMPLE_BITS-1:0] group_type;

endpackage : mogaf_pkg

`default_nettype wire

### rtl/core/mogaf_median.sv
// Combinational median select for one full group, by parallel rank counting.
`default_nettype none

module mogaf_median (
   input  mogaf_pkg::group_type  group_i,
   output mogaf_pkg::sample_type median_o
);
   import mogaf_pkg::*;

   logic [RANK_BITS-1:0] rank [GROUP_SIZE];

   // Rank of element i = number of elements ordered before it; ties broken
   // by position so every rank is unique.
   always_comb begin
      for (int i = 0; i < GROUP_SIZE; i++) begin
         rank[i] = '0;
         for (int j = 0; j < GROUP_SIZE; j++) begin
            if (j != i) begin
               if ((group_i[j] < group_i[i]) || ((group_i[j] == group_i[i]) && (j < i))) begin
                  rank[i] = rank[i] + 1'b1;
               end
            end
         end
      end
   end

   // Exactly one element holds the median rank.
   always_comb begin
      median_o = '0;
      for (int i = 0; i < GROUP_SIZE; i++) begin
         if (rank[i] == RANK_BITS'(MEDIAN_RANK)) begin
            median_o = median_o | group_i[i];
         end
      end
   end

endmodule : mogaf_median

`default_nettype wire

### rtl/core/median_of_groups_average_filter_core.sv
// Top level of the median-of-groups average filter.
//
// Takes one 12-bit converter sample per req_ transaction, cuts the stream
// into groups of five, takes the median (third smallest) of each group and
// emits on rsp_ the floor of the mean of four group medians after every
// twentieth sample; other samples produce no result. A sample is taken in
// every cycle unless req_tready is low: the fifth sample of a group goes
// into a capture register, from which the median network and the
// accumulator feed the result register, so a result shows on rsp_tvalid
// once the twentieth sample has passed the capture and result registers.
// Only a result left untaken at the output can hold the capture register
// and pull req_tready low.
// Reset is synchronous; the group buffer is not cleared, since every entry
// is written in the current group before it is read.
`default_nettype none

module median_of_groups_average_filter_core (
   input  wire                              clock,
   input  wire                              reset,
   // input stream: [11:0] sample, [15:12] unused
   input  wire                              req_tvalid,
   output logic                             req_tready,
   input  wire  [mogaf_pkg::TDATA_BITS-1:0] req_tdata,
   // result stream: [11:0] filtered, [15:12] zero
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   output logic [mogaf_pkg::TDATA_BITS-1:0] rsp_tdata
);
   import mogaf_pkg::*;

   // Earlier samples of the current group.
   sample_type group_ff [GROUP_SIZE-1];
   sample_type group_in [GROUP_SIZE-1];

   // Position of the next sample within its group, groups done in frame.
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [GRP_BITS-1:0] grp_cnt_ff, grp_cnt_in;

   // Capture register: last sample of a group.
   logic       s1_valid_ff, s1_valid_in;
   sample_type s1_sample_ff, s1_sample_in;
   logic       s1_frame_end_ff, s1_frame_end_in;

   // Running sum of group medians.
   sum_type sum_ff, sum_in;

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   sample_type rsp_data_ff, rsp_data_in;

   logic       req_fire;
   logic       group_last;
   logic       frame_last;
   logic       out_free;
   logic       s1_fire;
   sample_type sample;
   sample_type median;
   sum_type    sum_total;
   group_type  median_group;

   assign sample     = req_tdata[SAMPLE_BITS-1:0];
   assign req_fire   = req_tvalid & req_tready;
   assign group_last = (pos_ff == POS_BITS'(GROUP_SIZE - 1));
   assign frame_last = (grp_cnt_ff == GRP_BITS'(NUM_GROUPS - 1));

   // Capture stage drains unless it closes a frame and the output holds an untaken result.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (out_free || !s1_frame_end_ff);
   assign req_tready = !s1_valid_ff || s1_fire;

   // ---- group buffer and counters, updated per input transaction ----
   always_comb begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
         group_in[i] = group_ff[i];
      end
      pos_in          = pos_ff;
      grp_cnt_in      = grp_cnt_ff;
      s1_sample_in    = s1_sample_ff;
      s1_frame_end_in = s1_frame_end_ff;
      s1_valid_in     = s1_fire ? 1'b0 : s1_valid_ff;

      if (req_fire) begin
         if (group_last) begin
            pos_in          = '0;
            grp_cnt_in      = frame_last ? '0 : grp_cnt_ff + 1'b1;
            s1_sample_in    = sample;
            s1_frame_end_in = frame_last;
            s1_valid_in     = 1'b1;
         end else begin
            group_in[pos_ff[IDX_BITS-1:0]] = sample;
            pos_in = pos_ff + 1'b1;
         end
      end
   end

   // ---- median and accumulate ----
   always_comb begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
         median_group[i] = group_ff[i];
      end
      median_group[GROUP_SIZE-1] = s1_sample_ff;
   end

   mogaf_median u_median (
      .group_i  (median_group),
      .median_o (median)
   );

   assign sum_total = sum_ff + SUM_BITS'(median);

   always_comb begin
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (s1_fire) begin
         if (s1_frame_end_ff) begin
            sum_in       = '0;
            rsp_valid_in = 1'b1;
            rsp_data_in  = SAMPLE_BITS'(sum_total / NUM_GROUPS);
         end else begin
            sum_in = sum_total;
         end
      end
   end

   // ---- registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         grp_cnt_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         grp_cnt_ff   <= grp_cnt_in;
         s1_valid_ff  <= s1_valid_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
         group_ff[i] <= group_in[i];
      end
      s1_sample_ff    <= s1_sample_in;
      s1_frame_end_ff <= s1_frame_end_in;
      rsp_data_ff     <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_BITS'(rsp_data_ff);

endmodule : median_of_groups_average_filter_core

`default_nettype wire

### rtl/core/mogaf_checker.sv
// Port-level checks for the filter core, bound to the top level.
`default_nettype none

module mogaf_checker (
   input wire                              clock,
   input wire                              reset,
   input wire                              req_tvalid,
   input wire                              req_tready,
   input wire [mogaf_pkg::TDATA_BITS-1:0]  req_tdata,
   input wire                              rsp_tvalid,
   input wire                              rsp_tready,
   input wire [mogaf_pkg::TDATA_BITS-1:0]  rsp_tdata
);
   import mogaf_pkg::*;

   localparam int FRAME_LEN  = GROUP_SIZE * NUM_GROUPS;
   localparam int FRAME_BITS = $clog2(FRAME_LEN);

   logic [FRAME_BITS-1:0] cnt_ff;
   logic [1:0]            pending_ff;
   logic                  req_fire;
   logic                  rsp_fire;
   logic                  frame_done;

   assign req_fire   = req_tvalid && req_tready;
   assign rsp_fire   = rsp_tvalid && rsp_tready;
   assign frame_done = req_fire && (cnt_ff == FRAME_BITS'(FRAME_LEN - 1));

   // Frames closed on the input side whose result is not yet taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff     <= '0;
         pending_ff <= '0;
      end else begin
         if (req_fire) begin
            cnt_ff <= frame_done ? '0 : cnt_ff + 1'b1;
         end
         pending_ff <= pending_ff + {1'b0, frame_done} - {1'b0, rsp_fire};
      end
   end

   // No result transaction without a completed frame behind it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (pending_ff != 2'd0))
      else $error("result without a completed frame");

   // At most the capture stage and the output register hold frames.
   assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more frames in flight than pipeline stages");

   // An empty output never blocks the input.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("result dropped or changed while stalled");

endmodule : mogaf_checker

bind median_of_groups_average_filter_core mogaf_checker u_mogaf_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the median-of-groups average filter: random stream traffic, scoreboard check.
`timescale 1ns / 1ps

module tb_top;
   import mogaf_pkg::*;

   // Cycles without any transaction before the run is declared hung.
   // Slowest legal stretch is the long receiver hold-off (HOLD_CYCLES) plus a
   // receiver stall and a send gap of up to MAX_GAP each; this leaves ample margin.
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 800;
   localparam int HOLD_AT_RESULT = 12;
   // Result passes the capture and result registers after the frame's last sample; pad for safety.
   localparam int DRAIN_CYCLES   = 8;
   localparam int FRAME_ITEMS    = GROUP_SIZE * NUM_GROUPS;
   localparam int RANDOM_FRAMES  = 60;
   localparam int MAX_GAP        = 17;
   localparam sample_type SAMPLE_MAX = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // input stream: [11:0] sample, [15:12] zero
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_BITS-1:0] req_tdata  = '0;
   // result stream: [11:0] filtered, [15:12] zero
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_BITS-1:0] rsp_tdata;

   median_of_groups_average_filter_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Filter prediction: mirror of the group buffer, counters and the sum.
   // ---------------------------------------------------------------------
   sample_type  group_hold [GROUP_SIZE-1];
   int unsigned group_pos;
   int unsigned groups_done;
   int unsigned median_total;
   sample_type  filtered_expected [$];

   function automatic sample_type median_of_group(sample_type newest);
      sample_type vals [GROUP_SIZE];
      sample_type tmp;
      for (int i = 0; i < GROUP_SIZE - 1; i++) vals[i] = group_hold[i];
      vals[GROUP_SIZE-1] = newest;
      for (int i = 0; i < GROUP_SIZE - 1; i++) begin
         for (int j = 0; j < GROUP_SIZE - 1 - i; j++) begin
            if (vals[j] > vals[j+1]) begin
               tmp       = vals[j];
               vals[j]   = vals[j+1];
               vals[j+1] = tmp;
            end
         end
      end
      return vals[MEDIAN_RANK];
   endfunction

   // Advance the mirror by one accepted sample; queue a result on frame end.
   function automatic void predict_sample(sample_type s);
      if (group_pos < GROUP_SIZE - 1) begin
         group_hold[group_pos] = s;
         group_pos++;
      end else begin
         median_total += median_of_group(s);
         group_pos = 0;
         groups_done++;
         if (groups_done == NUM_GROUPS) begin
            filtered_expected.push_back(sample_type'(median_total / NUM_GROUPS));
            median_total = 0;
            groups_done  = 0;
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Mismatch reporting
   // ---------------------------------------------------------------------
   int error_count = 0;

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // ---------------------------------------------------------------------
   // Driver: presents samples from the pending queue with random gaps.
   // A calm stretch forces back-to-back transactions for a while.
   // ---------------------------------------------------------------------
   logic [TDATA_BITS-1:0] pending_samples [$];
   int send_wait  = 0;
   int send_calm  = 0;
   int samples_sent = 0;

   function automatic int draw_send_gap();
      if (send_calm == 0 && $urandom_range(0, 7) == 0) send_calm = $urandom_range(20, 60);
      if (send_calm > 0) begin
         send_calm--;
         return 0;
      end
      return $urandom_range(0, MAX_GAP);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
         send_wait  = 0;
         group_pos    = 0;
         groups_done  = 0;
         median_total = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata[SAMPLE_BITS-1:0]);
            samples_sent++;
            send_wait = draw_send_gap();
         end
         // Slot is free when nothing is offered or the offer just went in.
         if (!req_tvalid || req_tready) begin
            if (send_wait > 0) begin
               send_wait--;
               req_tvalid <= 1'b0;
            end else if (pending_samples.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= pending_samples.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random stall per result, plus one long hold-off so the result
   // register and capture register back up and req_tready drops.
   // ---------------------------------------------------------------------
   int recv_wait    = 0;
   int recv_calm    = 0;
   int hold_left    = 0;
   int results_seen = 0;
   sample_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         recv_wait  = 0;
         hold_left  = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (filtered_expected.size() == 0) begin
               report_mismatch($sformatf("unexpected result filtered=%0d",
                                         rsp_tdata[SAMPLE_BITS-1:0]));
            end else begin
               want = filtered_expected.pop_front();
               if (rsp_tdata[SAMPLE_BITS-1:0] !== want)
                  report_mismatch($sformatf("result %0d: filtered=%0d, want %0d",
                                            results_seen, rsp_tdata[SAMPLE_BITS-1:0], want));
            end
            if (rsp_tdata[TDATA_BITS-1:SAMPLE_BITS] !== '0)
               report_mismatch($sformatf("result %0d: padding bits %h not zero",
                                         results_seen, rsp_tdata[TDATA_BITS-1:SAMPLE_BITS]));
            if (recv_calm == 0 && $urandom_range(0, 5) == 0) recv_calm = $urandom_range(3, 8);
            if (recv_calm > 0) begin
               recv_calm--;
               recv_wait = 0;
            end else begin
               recv_wait = $urandom_range(0, MAX_GAP);
            end
            if (results_seen == HOLD_AT_RESULT) hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: cycles with no transaction on either side.
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   task automatic queue_sample(sample_type s);
      pending_samples.push_back(TDATA_BITS'(s));
   endtask

   initial begin
      int mode;
      int base;
      int tail;

      // Directed frame: all-max group, all-zero group, a tied group of
      // alternating bit patterns, then a spread group touching both ends.
      repeat (GROUP_SIZE) queue_sample(SAMPLE_MAX);
      repeat (GROUP_SIZE) queue_sample('0);
      queue_sample(12'hAAA); queue_sample(12'h555); queue_sample(12'h555);
      queue_sample(12'hAAA); queue_sample(12'h555);
      queue_sample(SAMPLE_MAX); queue_sample('0); queue_sample(12'h800);
      queue_sample(12'h001); queue_sample(sample_type'(SAMPLE_MAX - 1'b1));

      // Random frames; each frame picks a value profile, redrawn per group only after a fully random group.
      for (int f = 0; f < RANDOM_FRAMES; f++) begin
         mode = $urandom_range(0, 19);
         for (int g = 0; g < NUM_GROUPS; g++) begin
            base = $urandom_range(0, 4095 - 7);
            for (int k = 0; k < GROUP_SIZE; k++) begin
               case (mode)
                  0:       queue_sample(SAMPLE_MAX);               // saturated frame
                  1:       queue_sample('0);                       // silent frame
                  2, 3, 4: queue_sample($urandom_range(0, 1) ? SAMPLE_MAX : sample_type'(0));
                  5, 6, 7: queue_sample(sample_type'(base + $urandom_range(0, 3)));  // ties
                  8:       queue_sample(sample_type'(base));       // flat group
                  default: queue_sample(sample_type'($urandom_range(0, 4095)));
               endcase
            end
            if (mode > 8) mode = $urandom_range(0, 19);
         end
      end

      // Partial frame at the end: must produce nothing.
      tail = $urandom_range(1, FRAME_ITEMS - 1);
      repeat (tail) queue_sample(sample_type'($urandom_range(0, 4095)));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_samples.size() > 0 || req_tvalid || filtered_expected.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (filtered_expected.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", filtered_expected.size()));

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
